FILE: rtl/ifh_pkg.sv
// Shared types and constants for the indexed four-ary min-heap.
package ifh_pkg;

    localparam int KeyW = 63;
    localparam int VidW = 10;
    localparam int VertexSpace = 1024;

    // Heap fan-out; children of slot i start at i * Arity + 1.
    localparam int Arity    = 4;
    localparam int ArityLog = 2;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DECREASE = 2'd1;
    localparam logic [1:0] REQ_EXTRACT  = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_ABSENT  = 3'd4;

endpackage

FILE: rtl/ifh_req_if.sv
// Valid/ready channel carrying one heap request.
interface ifh_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [ifh_pkg::VidW-1:0]  vertex_id;
    logic [ifh_pkg::KeyW-1:0]  new_key;
    modport source (output valid, req_type, vertex_id, new_key, input ready);
    modport sink (input valid, req_type, vertex_id, new_key, output ready);
endinterface

FILE: rtl/ifh_rsp_if.sv
// Valid/ready channel carrying one heap response.
interface ifh_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [ifh_pkg::KeyW-1:0]  min_key;
    logic [ifh_pkg::VidW-1:0]  min_vertex;
    logic                      was_present;
    logic [10:0]               entry_count;
    modport source (output valid, status, min_key, min_vertex, was_present, entry_count,
                    input ready);
    modport sink (input valid, status, min_key, min_vertex, was_present, entry_count,
                  output ready);
endinterface

FILE: rtl/indexed_four_ary_min_heap.sv
// Indexed four-ary min-heap: top level with slot memory, position map and sift sequencer.
// Insert and decrease climb toward the root, reading and comparing one parent per level; extract
// moves the last slot's entry to the root and sinks it, comparing each level's children in turn.
// Clear zeroes the heap size and sweeps the whole position map absent, then responds.
// Throughput: one request at a time; a new request is taken once the response register is free.
// Reset: asynchronous, active low; heap size zero, then a sweep marks all 1024 vertices absent.
module indexed_four_ary_min_heap #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    ifh_req_if.sink     req,
    ifh_rsp_if.source   rsp
);
    localparam int SlotW = $clog2(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int ArW   = $clog2(ifh_pkg::Arity + 1);
    localparam int KW    = ifh_pkg::KeyW;
    localparam int VW    = ifh_pkg::VidW;
    localparam int MapW  = SlotW + 1;   // present bit on top of the slot number
    localparam int MulW  = SlotW + 4;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SWEEP  = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;  // read position map entry
    localparam logic [3:0] S_DEC    = 4'd3;  // check current key for decrease
    localparam logic [3:0] S_UPRD   = 4'd4;  // read parent slot
    localparam logic [3:0] S_UPCMP  = 4'd5;  // compare with parent
    localparam logic [3:0] S_XRD    = 4'd6;  // read last slot for extract
    localparam logic [3:0] S_DNRD   = 4'd7;  // issue first child read
    localparam logic [3:0] S_DNCMP  = 4'd8;  // compare children, one a cycle
    localparam logic [3:0] S_DNMOVE = 4'd9;
    localparam logic [3:0] S_PLACE  = 4'd10; // final placement of moving entry
    localparam logic [3:0] S_RESP   = 4'd11;
    localparam logic [3:0] S_X0     = 4'd12; // read root

    // Slot memory: key and vertex, one read and one write port, registered read.
    logic [KW-1:0] key_mem [CAPACITY];
    logic [VW-1:0] vid_mem [CAPACITY];
    logic [MapW-1:0] map_mem [ifh_pkg::VertexSpace];

    logic [3:0]       state_reg, state_next;
    logic [CntW-1:0]  size_reg, size_next;
    logic [VW-1:0]    sweep_reg, sweep_next;
    logic [1:0]       kind_reg, kind_next;
    logic [VW-1:0]    mv_vid_reg, mv_vid_next;     // moving vertex
    logic [KW-1:0]    mv_key_reg, mv_key_next;     // moving key
    logic [SlotW-1:0] at_reg, at_next;
    logic [SlotW-1:0] up_reg, up_next;
    logic [CntW-1:0]  first_reg, first_next;
    logic [ArW-1:0]   cidx_reg, cidx_next;
    logic [ArW-1:0]   ccnt_reg, ccnt_next;
    logic [KW-1:0]    best_key_reg, best_key_next;
    logic [VW-1:0]    best_vid_reg, best_vid_next;
    logic [SlotW-1:0] best_at_reg, best_at_next;
    logic [2:0]       st_reg, st_next;
    logic [KW-1:0]    ok_reg, ok_next;
    logic [VW-1:0]    ov_reg, ov_next;
    logic             pres_reg, pres_next;
    logic             rv_reg, rv_next;

    // Memory port controls.
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic [KW-1:0]    rd_key;
    logic [VW-1:0]    rd_vid;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    logic [KW-1:0]    wr_key;
    logic [VW-1:0]    wr_vid;
    logic             mrd_en;
    logic [VW-1:0]    mrd_addr;
    logic [MapW-1:0]  mrd_data;
    logic             mwr_en;
    logic [VW-1:0]    mwr_addr;
    logic [MapW-1:0]  mwr_data;

    // Shared unit: one key comparator used by every sift step.
    logic [KW-1:0] cmp_a, cmp_b;
    logic          cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    logic [MulW-1:0] first_wide;
    logic [CntW-1:0] remain;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key <= key_mem[rd_addr];
            rd_vid <= vid_mem[rd_addr];
        end
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            vid_mem[wr_addr] <= wr_vid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mrd_en)
        begin
            mrd_data <= map_mem[mrd_addr];
        end
        if (mwr_en)
        begin
            map_mem[mwr_addr] <= mwr_data;
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !rv_reg;
    assign rsp.valid = rv_reg;
    assign rsp.status = st_reg;
    assign rsp.min_key = ok_reg;
    assign rsp.min_vertex = ov_reg;
    assign rsp.was_present = pres_reg;
    assign rsp.entry_count = 11'(size_reg);

    always_comb
    begin
        state_next = state_reg;
        size_next = size_reg;
        sweep_next = sweep_reg;
        kind_next = kind_reg;
        mv_vid_next = mv_vid_reg;
        mv_key_next = mv_key_reg;
        at_next = at_reg;
        up_next = up_reg;
        first_next = first_reg;
        cidx_next = cidx_reg;
        ccnt_next = ccnt_reg;
        best_key_next = best_key_reg;
        best_vid_next = best_vid_reg;
        best_at_next = best_at_reg;
        st_next = st_reg;
        ok_next = ok_reg;
        ov_next = ov_reg;
        pres_next = pres_reg;
        rv_next = rv_reg;
        rd_en = 1'b0;
        rd_addr = at_reg;
        wr_en = 1'b0;
        wr_addr = at_reg;
        wr_key = mv_key_reg;
        wr_vid = mv_vid_reg;
        mrd_en = 1'b0;
        mrd_addr = mv_vid_reg;
        mwr_en = 1'b0;
        mwr_addr = mv_vid_reg;
        mwr_data = {1'b1, at_reg};
        cmp_a = mv_key_reg;
        cmp_b = rd_key;
        first_wide = (MulW'(at_reg) << ifh_pkg::ArityLog) + MulW'(1);
        remain = size_reg - first_reg;

        if (rv_reg && rsp.ready)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    kind_next = req.req_type;
                    mv_vid_next = req.vertex_id;
                    mv_key_next = req.new_key;
                    st_next = ifh_pkg::ST_OK;
                    ok_next = '0;
                    ov_next = '0;
                    pres_next = 1'b0;
                    case (req.req_type)
                        ifh_pkg::REQ_INSERT, ifh_pkg::REQ_DECREASE:
                        begin
                            mrd_en = 1'b1;
                            mrd_addr = req.vertex_id;
                            state_next = S_LOOK;
                        end
                        ifh_pkg::REQ_EXTRACT:
                        begin
                            if (size_reg == '0)
                            begin
                                st_next = ifh_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = '0;
                                state_next = S_X0;
                            end
                        end
                        default:
                        begin
                            size_next = '0;
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                // Marks one vertex absent per cycle.
                mwr_en = 1'b1;
                mwr_addr = sweep_reg;
                mwr_data = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == VW'(ifh_pkg::VertexSpace - 1))
                begin
                    state_next = (kind_reg == ifh_pkg::REQ_CLEAR) ? S_RESP : S_IDLE;
                end
            end
            S_LOOK:
            begin
                pres_next = mrd_data[MapW-1];
                if (kind_reg == ifh_pkg::REQ_INSERT)
                begin
                    if (size_reg >= CntW'(CAPACITY))
                    begin
                        st_next = ifh_pkg::ST_FULL;
                        state_next = S_RESP;
                    end
                    else if (mrd_data[MapW-1])
                    begin
                        st_next = ifh_pkg::ST_PRESENT;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        at_next = SlotW'(size_reg);
                        size_next = size_reg + 1'b1;
                        state_next = S_UPRD;
                    end
                end
                else if (!mrd_data[MapW-1] || CntW'(mrd_data[SlotW-1:0]) >= size_reg)
                begin
                    st_next = ifh_pkg::ST_ABSENT;
                    state_next = S_RESP;
                end
                else
                begin
                    at_next = mrd_data[SlotW-1:0];
                    rd_en = 1'b1;
                    rd_addr = mrd_data[SlotW-1:0];
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (cmp_lt)
                begin
                    state_next = S_UPRD;
                end
                else
                begin
                    st_next = ifh_pkg::ST_ABSENT;
                    state_next = S_RESP;
                end
            end
            S_UPRD:
            begin
                if (at_reg == '0)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    up_next = SlotW'((at_reg - 1'b1) >> ifh_pkg::ArityLog);
                    rd_en = 1'b1;
                    rd_addr = SlotW'((at_reg - 1'b1) >> ifh_pkg::ArityLog);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                // Parent moves down when the moving key is strictly smaller.
                if (cmp_lt)
                begin
                    wr_en = 1'b1;
                    wr_addr = at_reg;
                    wr_key = rd_key;
                    wr_vid = rd_vid;
                    mwr_en = 1'b1;
                    mwr_addr = rd_vid;
                    mwr_data = {1'b1, at_reg};
                    at_next = up_reg;
                    state_next = S_UPRD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_X0:
            begin
                ok_next = rd_key;
                ov_next = rd_vid;
                mwr_en = 1'b1;
                mwr_addr = rd_vid;
                mwr_data = '0;
                size_next = size_reg - 1'b1;
                if (size_reg == CntW'(1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = SlotW'(size_reg - 1'b1);
                    state_next = S_XRD;
                end
            end
            S_XRD:
            begin
                mv_key_next = rd_key;
                mv_vid_next = rd_vid;
                at_next = '0;
                state_next = S_DNRD;
            end
            S_DNRD:
            begin
                if (first_wide >= MulW'(size_reg))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    first_next = CntW'(first_wide);
                    cidx_next = '0;
                    rd_en = 1'b1;
                    rd_addr = SlotW'(first_wide);
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP:
            begin
                // One child arrives per cycle; keep the first smallest.
                if (cidx_reg == '0)
                begin
                    ccnt_next = (remain > CntW'(ifh_pkg::Arity)) ? ArW'(ifh_pkg::Arity)
                                                                 : ArW'(remain);
                end
                cmp_a = rd_key;
                cmp_b = best_key_reg;
                if (cidx_reg == '0 || cmp_lt)
                begin
                    best_key_next = rd_key;
                    best_vid_next = rd_vid;
                    best_at_next = SlotW'(first_reg + CntW'(cidx_reg));
                end
                cidx_next = cidx_reg + 1'b1;
                if ((cidx_reg == '0) ? (remain == CntW'(1) || ifh_pkg::Arity == 1)
                                     : (cidx_reg + 1'b1 == ccnt_reg))
                begin
                    state_next = S_DNMOVE;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = SlotW'(first_reg + CntW'(cidx_reg) + 1'b1);
                end
            end
            S_DNMOVE:
            begin
                cmp_a = best_key_reg;
                cmp_b = mv_key_reg;
                if (cmp_lt)
                begin
                    wr_en = 1'b1;
                    wr_addr = at_reg;
                    wr_key = best_key_reg;
                    wr_vid = best_vid_reg;
                    mwr_en = 1'b1;
                    mwr_addr = best_vid_reg;
                    mwr_data = {1'b1, at_reg};
                    at_next = best_at_reg;
                    state_next = S_DNRD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                wr_en = 1'b1;
                mwr_en = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rv_reg)
                begin
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            size_reg <= '0;
            sweep_reg <= '0;
            kind_reg <= ifh_pkg::REQ_INSERT;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg <= size_next;
            sweep_reg <= sweep_next;
            kind_reg <= kind_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_vid_reg <= mv_vid_next;
        mv_key_reg <= mv_key_next;
        at_reg <= at_next;
        up_reg <= up_next;
        first_reg <= first_next;
        cidx_reg <= cidx_next;
        ccnt_reg <= ccnt_next;
        best_key_reg <= best_key_next;
        best_vid_reg <= best_vid_next;
        best_at_reg <= best_at_next;
        st_reg <= st_next;
        ok_reg <= ok_next;
        ov_reg <= ov_next;
        pres_reg <= pres_next;
    end

endmodule
